FILE: hw/rtl/imu_sched_pkg.sv
// Shared types and constants for the dual-sensor IMU read scheduler.
// Depends on nothing; imported by imu_sched_step and the top level.

package imu_sched_pkg;

    localparam int IMU_TIME_WIDTH = 32;
    localparam int CMD_WIDTH      = 3;
    localparam int CFG_WIDTH      = 8;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int SEQ_WIDTH      = 32;
    localparam int LAUNCH_WIDTH   = 2;
    localparam int BYTES_WIDTH    = 4;

    localparam logic [CFG_WIDTH-1:0] FALLBACK_MS_RESET = 8'd5;
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_MS_RESET  = 8'd5;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FALLBACK_MS = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TIMEOUT_MS  = 2'd1;

    localparam logic [LAUNCH_WIDTH-1:0] LAUNCH_NONE  = 2'd0;
    localparam logic [LAUNCH_WIDTH-1:0] LAUNCH_GYRO  = 2'd1;
    localparam logic [LAUNCH_WIDTH-1:0] LAUNCH_ACCEL = 2'd2;

    localparam logic [BYTES_WIDTH-1:0] GYRO_BYTES  = 4'd7;
    localparam logic [BYTES_WIDTH-1:0] ACCEL_BYTES = 4'd8;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_POLL        = 3'd0,
        CMD_GYRO_READY  = 3'd1,
        CMD_ACCEL_READY = 3'd2,
        CMD_XFER_DONE   = 3'd3,
        CMD_XFER_ERROR  = 3'd4,
        CMD_ENABLE      = 3'd5,
        CMD_DISABLE     = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_GYRO  = 2'd1,
        MODE_ACCEL = 2'd2
    } mode_t;

    // Scheduler control state
    typedef struct packed {
        mode_t mode;
        logic  enabled;
        logic  valid;
        logic  gyro_in;
        logic  accel_in;
        logic  pend_gyro;
        logic  pend_accel;
        logic  accel_turn;
    } flags_t;

    // One result beat
    typedef struct packed {
        logic [LAUNCH_WIDTH-1:0] launched;
        logic [BYTES_WIDTH-1:0]  transfer_bytes;
        logic                    gyro_select;
        logic                    accel_select;
        logic                    bus_abort;
        logic                    published;
        logic                    sample_valid;
        logic [SEQ_WIDTH-1:0]    sample_seq;
    } result_t;

endpackage

FILE: hw/rtl/imu_dual_sensor_read_scheduler_top.sv
// Top level of the dual-sensor IMU read scheduler: input register, state, result register.
// Depends on imu_sched_pkg and imu_sched_step.

// The scheduler takes one event beat per clock while in_stall is low and returns exactly one
// result beat per event. An accepted event lands in the input register; the step logic (flag
// updates, two time comparisons and the read selection) then runs in one pass, and when the
// result stage advances the state registers update and the result is captured in the output
// register. A new event may follow every cycle while in_stall is low. in_stall rises only
// while the result register is full and stalled. Time differences wrap modulo 2^TIME_WIDTH.
// The configuration port is always ready; write it only while no event is in flight.

module imu_dual_sensor_read_scheduler_top
    import imu_sched_pkg::*;
#(
    parameter int TIME_WIDTH = IMU_TIME_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // event channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_WIDTH-1:0]     cmd,
    input  logic [TIME_WIDTH-1:0]    now,
    input  logic                     bus_ready,
    input  logic                     start_ok,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [LAUNCH_WIDTH-1:0]  launched,
    output logic [BYTES_WIDTH-1:0]   transfer_bytes,
    output logic                     gyro_select,
    output logic                     accel_select,
    output logic                     bus_abort,
    output logic                     published,
    output logic                     sample_valid,
    output logic [SEQ_WIDTH-1:0]     sample_seq,
    // configuration channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data
);

    // input register
    logic                  in_valid_reg;
    logic [CMD_WIDTH-1:0]  cmd_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  bus_ready_reg;
    logic                  start_ok_reg;

    // scheduler state
    flags_t                flags_reg;
    flags_t                flags_next;
    logic [SEQ_WIDTH-1:0]  seq_reg;
    logic [SEQ_WIDTH-1:0]  seq_next;
    logic [TIME_WIDTH-1:0] last_update_reg;
    logic [TIME_WIDTH-1:0] last_transfer_reg;
    logic                  update_stamp;
    logic                  transfer_stamp;

    // configuration
    logic [CFG_WIDTH-1:0]  fallback_ms_reg;
    logic [CFG_WIDTH-1:0]  timeout_ms_reg;

    // result register
    logic                  out_valid_reg;
    result_t               result_reg;
    result_t               result_next;

    logic                  advance;
    logic                  fire;

    // The result stage moves whenever it is empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Capture an event beat; hold it while the result side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            cmd_reg       <= cmd;
            now_reg       <= now;
            bus_ready_reg <= bus_ready;
            start_ok_reg  <= start_ok;
        end
    end

    imu_sched_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .flags          (flags_reg),
        .seq            (seq_reg),
        .last_update    (last_update_reg),
        .last_transfer  (last_transfer_reg),
        .fallback_ms    (fallback_ms_reg),
        .timeout_ms     (timeout_ms_reg),
        .cmd            (cmd_reg),
        .now            (now_reg),
        .bus_ready      (bus_ready_reg),
        .start_ok       (start_ok_reg),
        .flags_next     (flags_next),
        .seq_next       (seq_next),
        .update_stamp   (update_stamp),
        .transfer_stamp (transfer_stamp),
        .result         (result_next)
    );

    // Advance the scheduler state only when the event's result is captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flags_reg         <= '0;
            seq_reg           <= '0;
            last_update_reg   <= '0;
            last_transfer_reg <= '0;
        end
        else if (fire) begin
            flags_reg <= flags_next;
            seq_reg   <= seq_next;
            if (update_stamp)
                last_update_reg <= now_reg;
            if (transfer_stamp)
                last_transfer_reg <= now_reg;
        end
    end

    // Configuration writes; indexes past the register list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fallback_ms_reg <= FALLBACK_MS_RESET;
            timeout_ms_reg  <= TIMEOUT_MS_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FALLBACK_MS: fallback_ms_reg <= cfg_data;
                CFG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_data;
                default:         fallback_ms_reg <= fallback_ms_reg;
            endcase
        end
    end

    // Result register; a taken beat is replaced or dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign launched       = result_reg.launched;
    assign transfer_bytes = result_reg.transfer_bytes;
    assign gyro_select    = result_reg.gyro_select;
    assign accel_select   = result_reg.accel_select;
    assign bus_abort      = result_reg.bus_abort;
    assign published      = result_reg.published;
    assign sample_valid   = result_reg.sample_valid;
    assign sample_seq     = result_reg.sample_seq;

    // A launched read keeps its own chip select asserted and the other released
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && launched == LAUNCH_GYRO) |-> (gyro_select && !accel_select))
        else $error("gyro launch without gyro chip select");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && launched == LAUNCH_ACCEL) |-> (accel_select && !gyro_select))
        else $error("accel launch without accel chip select");

    // A published sample is always marked valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && published) |-> sample_valid)
        else $error("sample published but not valid");

    // The input side stalls only behind a full, stalled result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while result stage free");

endmodule

FILE: hw/rtl/imu_sched_step.sv
// Event step logic of the IMU read scheduler: next state and result for one event.
// Depends on imu_sched_pkg; purely combinational, state registers live in the top level.

module imu_sched_step
    import imu_sched_pkg::*;
#(
    parameter int TIME_WIDTH = IMU_TIME_WIDTH
)
(
    input  flags_t                  flags,
    input  logic [SEQ_WIDTH-1:0]    seq,
    input  logic [TIME_WIDTH-1:0]   last_update,
    input  logic [TIME_WIDTH-1:0]   last_transfer,
    input  logic [CFG_WIDTH-1:0]    fallback_ms,
    input  logic [CFG_WIDTH-1:0]    timeout_ms,
    input  logic [CMD_WIDTH-1:0]    cmd,
    input  logic [TIME_WIDTH-1:0]   now,
    input  logic                    bus_ready,
    input  logic                    start_ok,
    output flags_t                  flags_next,
    output logic [SEQ_WIDTH-1:0]    seq_next,
    output logic                    update_stamp,
    output logic                    transfer_stamp,
    output result_t                 result
);

    typedef struct packed {
        flags_t                  f;
        logic                    ready;
        logic                    abort;
        logic                    stamp;
        logic [LAUNCH_WIDTH-1:0] launched;
        logic                    done;
    } work_t;

    // Start a read of one part; bus busy leaves it pending
    function automatic work_t launch(work_t w_in, logic accel, logic ok);
        work_t w;
        w = w_in;
        if (!w.ready) begin
            if (accel)
                w.f.pend_accel = 1'b1;
            else
                w.f.pend_gyro = 1'b1;
        end
        else begin
            w.stamp = 1'b1;
            if (ok) begin
                w.f.mode   = accel ? MODE_ACCEL : MODE_GYRO;
                w.launched = accel ? LAUNCH_ACCEL : LAUNCH_GYRO;
                w.done     = 1'b1;
            end
        end
        return w;
    endfunction

    // Pick the next pending part, alternating when both wait
    function automatic work_t service(work_t w_in, logic ok);
        work_t w;
        w = w_in;
        if (w.f.mode == MODE_IDLE) begin
            if (w.f.pend_accel && w.f.pend_gyro) begin
                if (w.f.accel_turn) begin
                    w.f.pend_accel = 1'b0;
                    w = launch(w, 1'b1, ok);
                end
                else begin
                    w.f.pend_gyro = 1'b0;
                    w = launch(w, 1'b0, ok);
                end
            end
            if (!w.done && w.f.pend_gyro) begin
                w.f.pend_gyro = 1'b0;
                w = launch(w, 1'b0, ok);
            end
            if (!w.done && w.f.pend_accel) begin
                w.f.pend_accel = 1'b0;
                w = launch(w, 1'b1, ok);
            end
        end
        return w;
    endfunction

    // Drop the transfer; abort when the bus is still busy
    function automatic work_t reset_xfer(work_t w_in);
        work_t w;
        w = w_in;
        if (!w.ready) begin
            w.abort = 1'b1;
            w.ready = 1'b1;
        end
        w.f.mode       = MODE_IDLE;
        w.f.gyro_in    = 1'b0;
        w.f.accel_in   = 1'b0;
        w.f.pend_gyro  = 1'b0;
        w.f.pend_accel = 1'b0;
        return w;
    endfunction

    logic [TIME_WIDTH-1:0] xfer_elapsed;
    logic [TIME_WIDTH-1:0] update_elapsed;
    logic                  xfer_late;
    logic                  update_late;
    work_t                 w;
    logic                  seq_inc;
    logic                  seq_clear;
    logic                  upd;
    logic                  was_gyro;

    assign xfer_elapsed   = now - last_transfer;
    assign update_elapsed = now - last_update;
    assign xfer_late      = xfer_elapsed > TIME_WIDTH'(timeout_ms);
    assign update_late    = update_elapsed > TIME_WIDTH'(fallback_ms);

    always_comb
    begin
        w          = '0;
        w.f        = flags;
        w.ready    = bus_ready;
        seq_inc    = 1'b0;
        seq_clear  = 1'b0;
        upd        = 1'b0;
        was_gyro   = 1'b0;
        case (cmd_t'(cmd))
            CMD_POLL:
            begin
                if (w.f.enabled) begin
                    if ((w.f.mode != MODE_IDLE || !w.ready) && xfer_late) begin
                        w = reset_xfer(w);
                        w.f.pend_accel = 1'b1;
                        w.f.pend_gyro  = 1'b1;
                        w.stamp        = 1'b1;
                    end
                    if (update_late) begin
                        w.f.pend_accel = 1'b1;
                        w.f.pend_gyro  = 1'b1;
                    end
                    w = service(w, start_ok);
                end
            end
            CMD_GYRO_READY:
            begin
                if (w.f.enabled)
                    w.f.pend_gyro = 1'b1;
            end
            CMD_ACCEL_READY:
            begin
                if (w.f.enabled)
                    w.f.pend_accel = 1'b1;
            end
            CMD_XFER_DONE:
            begin
                if (w.f.mode == MODE_GYRO || w.f.mode == MODE_ACCEL) begin
                    was_gyro = (w.f.mode == MODE_GYRO);
                    if (was_gyro)
                        w.f.gyro_in = 1'b1;
                    else
                        w.f.accel_in = 1'b1;
                    upd = 1'b1;
                    w.f.accel_turn = was_gyro;
                    if (w.f.gyro_in && w.f.accel_in) begin
                        w.f.valid    = 1'b1;
                        seq_inc      = 1'b1;
                        w.f.gyro_in  = 1'b0;
                        w.f.accel_in = 1'b0;
                    end
                    w.f.mode = MODE_IDLE;
                    w = service(w, start_ok);
                end
                else begin
                    w = reset_xfer(w);
                end
            end
            CMD_XFER_ERROR:
            begin
                w.abort = 1'b1;
                w = reset_xfer(w);
                w.f.pend_accel = 1'b1;
                w.f.pend_gyro  = 1'b1;
                w.stamp        = 1'b1;
            end
            CMD_ENABLE:
            begin
                w.f.enabled    = 1'b1;
                w.f.valid      = 1'b0;
                w.f.gyro_in    = 1'b0;
                w.f.accel_in   = 1'b0;
                w.f.pend_gyro  = 1'b1;
                w.f.pend_accel = 1'b1;
                w.f.accel_turn = 1'b0;
                w.f.mode       = MODE_IDLE;
                seq_clear      = 1'b1;
                upd            = 1'b1;
                w.stamp        = 1'b1;
            end
            CMD_DISABLE:
            begin
                w.f.enabled = 1'b0;
                w = reset_xfer(w);
            end
            default:
            begin
                w = w;
            end
        endcase
    end

    always_comb
    begin
        if (seq_clear)
            seq_next = '0;
        else if (seq_inc)
            seq_next = seq + SEQ_WIDTH'(1);
        else
            seq_next = seq;
    end

    assign flags_next     = w.f;
    assign update_stamp   = upd;
    assign transfer_stamp = w.stamp;

    always_comb
    begin
        result.launched = w.launched;
        case (w.launched)
            LAUNCH_GYRO:  result.transfer_bytes = GYRO_BYTES;
            LAUNCH_ACCEL: result.transfer_bytes = ACCEL_BYTES;
            default:      result.transfer_bytes = '0;
        endcase
        result.gyro_select  = (w.f.mode == MODE_GYRO);
        result.accel_select = (w.f.mode == MODE_ACCEL);
        result.bus_abort    = w.abort;
        result.published    = seq_inc;
        result.sample_valid = w.f.valid;
        result.sample_seq   = seq_next;
    end

endmodule

FILE: tb/tb_imu_dual_sensor_read_scheduler_top.sv
// Self-checking testbench for the dual-sensor IMU read scheduler top level.
// Depends on imu_sched_pkg and the scheduler RTL; predicts every result beat in-line.

`timescale 1ns / 1ps

module tb_imu_dual_sensor_read_scheduler_top;
    import imu_sched_pkg::*;

    // Command seven is not an event; the block must leave its state alone.
    localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 3'd7;
    localparam int PHASE_ITEMS = 340;

    // One event beat as the driver offers it
    typedef struct packed {
        logic [CMD_WIDTH-1:0]      code;
        logic [IMU_TIME_WIDTH-1:0] stamp;
        logic                      rdy;
        logic                      ok;
    } sched_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [CMD_WIDTH-1:0]      cmd       = CMD_POLL;
    logic [IMU_TIME_WIDTH-1:0] now       = '0;
    logic                      bus_ready = 1'b0;
    logic                      start_ok  = 1'b0;

    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [LAUNCH_WIDTH-1:0]   launched;
    logic [BYTES_WIDTH-1:0]    transfer_bytes;
    logic                      gyro_select;
    logic                      accel_select;
    logic                      bus_abort;
    logic                      published;
    logic                      sample_valid;
    logic [SEQ_WIDTH-1:0]      sample_seq;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_WIDTH-1:0]      cfg_data  = '0;

    imu_dual_sensor_read_scheduler_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .now            (now),
        .bus_ready      (bus_ready),
        .start_ok       (start_ok),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .launched       (launched),
        .transfer_bytes (transfer_bytes),
        .gyro_select    (gyro_select),
        .accel_select   (accel_select),
        .bus_abort      (bus_abort),
        .published      (published),
        .sample_valid   (sample_valid),
        .sample_seq     (sample_seq),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // Event beats waiting for the driver, and predicted result beats waiting for the DUT
    sched_event_t bus_event_q[$];
    result_t      read_plan_q[$];
    int unsigned  fault_count = 0;

    // Idle rates in percent; the receiver hold-off counts down in its own process
    int unsigned  send_idle_pct = 24;
    int unsigned  recv_idle_pct = 51;
    logic         hold_start = 1'b0;
    int unsigned  hold_left = 0;

    // Running millisecond clock used when building events
    logic [IMU_TIME_WIDTH-1:0] t_stamp = '0;

    // ------------------------------------------------------------------
    // Scheduler prediction: private copy of the control state and registers
    // ------------------------------------------------------------------
    logic [CFG_WIDTH-1:0]      m_fallback = FALLBACK_MS_RESET;
    logic [CFG_WIDTH-1:0]      m_timeout  = TIMEOUT_MS_RESET;
    mode_t                     m_mode     = MODE_IDLE;
    logic                      m_en = 1'b0, m_valid = 1'b0;
    logic                      m_have_g = 1'b0, m_have_a = 1'b0;
    logic                      m_pend_g = 1'b0, m_pend_a = 1'b0, m_pref_a = 1'b0;
    logic [SEQ_WIDTH-1:0]      m_seq = '0;
    logic [IMU_TIME_WIDTH-1:0] m_upd_t = '0, m_xfer_t = '0;

    // Per-beat scratch
    logic                      s_ready, s_ok, s_abort, s_pub;
    logic [IMU_TIME_WIDTH-1:0] s_now;
    logic [LAUNCH_WIDTH-1:0]   s_launch;
    logic [BYTES_WIDTH-1:0]    s_bytes;

    // Drop back to idle, forget partial data; abort an unready bus, which then counts as ready.
    function automatic void clear_transfer();
        if (!s_ready) begin
            s_abort = 1'b1;
            s_ready = 1'b1;
        end
        m_mode   = MODE_IDLE;
        m_have_g = 1'b0;
        m_have_a = 1'b0;
        m_pend_g = 1'b0;
        m_pend_a = 1'b0;
    endfunction

    function automatic bit start_read(bit to_accel);
        if (m_mode != MODE_IDLE)
            return 1'b0;
        if (!s_ready) begin
            if (to_accel)
                m_pend_a = 1'b1;
            else
                m_pend_g = 1'b1;
            return 1'b0;
        end
        m_xfer_t = s_now;
        if (!s_ok)
            return 1'b0;
        if (to_accel) begin
            m_mode   = MODE_ACCEL;
            s_launch = LAUNCH_ACCEL;
            s_bytes  = ACCEL_BYTES;
        end
        else begin
            m_mode   = MODE_GYRO;
            s_launch = LAUNCH_GYRO;
            s_bytes  = GYRO_BYTES;
        end
        return 1'b1;
    endfunction

    // Pick the next read; alternate when both parts are pending.
    function automatic void pick_read();
        if (m_mode != MODE_IDLE)
            return;
        if (m_pend_a && m_pend_g) begin
            if (m_pref_a) begin
                m_pend_a = 1'b0;
                if (start_read(1'b1))
                    return;
            end
            else begin
                m_pend_g = 1'b0;
                if (start_read(1'b0))
                    return;
            end
        end
        if (m_pend_g) begin
            m_pend_g = 1'b0;
            if (start_read(1'b0))
                return;
        end
        if (m_pend_a) begin
            m_pend_a = 1'b0;
            void'(start_read(1'b1));
        end
    endfunction

    function automatic result_t schedule_step(sched_event_t ev);
        result_t r;
        bit      was_gyro;
        s_now    = ev.stamp;
        s_ready  = ev.rdy;
        s_ok     = ev.ok;
        s_abort  = 1'b0;
        s_pub    = 1'b0;
        s_launch = LAUNCH_NONE;
        s_bytes  = '0;
        case (ev.code)
            CMD_POLL:
                if (m_en) begin
                    if ((m_mode != MODE_IDLE || !s_ready) &&
                        (s_now - m_xfer_t) > {24'd0, m_timeout}) begin
                        clear_transfer();
                        m_pend_a = 1'b1;
                        m_pend_g = 1'b1;
                        m_xfer_t = s_now;
                    end
                    if ((s_now - m_upd_t) > {24'd0, m_fallback}) begin
                        m_pend_a = 1'b1;
                        m_pend_g = 1'b1;
                    end
                    pick_read();
                end
            CMD_GYRO_READY:
                if (m_en)
                    m_pend_g = 1'b1;
            CMD_ACCEL_READY:
                if (m_en)
                    m_pend_a = 1'b1;
            CMD_XFER_DONE:
                if (m_mode == MODE_GYRO || m_mode == MODE_ACCEL) begin
                    was_gyro = (m_mode == MODE_GYRO);
                    if (was_gyro)
                        m_have_g = 1'b1;
                    else
                        m_have_a = 1'b1;
                    m_upd_t  = s_now;
                    m_pref_a = was_gyro;
                    if (m_have_g && m_have_a) begin
                        m_valid  = 1'b1;
                        m_seq    = m_seq + 1;
                        m_have_g = 1'b0;
                        m_have_a = 1'b0;
                        s_pub    = 1'b1;
                    end
                    m_mode = MODE_IDLE;
                    pick_read();
                end
                else
                    clear_transfer();
            CMD_XFER_ERROR: begin
                s_abort = 1'b1;
                clear_transfer();
                m_pend_a = 1'b1;
                m_pend_g = 1'b1;
                m_xfer_t = s_now;
            end
            CMD_ENABLE: begin
                m_en     = 1'b1;
                m_valid  = 1'b0;
                m_have_g = 1'b0;
                m_have_a = 1'b0;
                m_pend_g = 1'b1;
                m_pend_a = 1'b1;
                m_pref_a = 1'b0;
                m_seq    = '0;
                m_upd_t  = s_now;
                m_xfer_t = s_now;
                m_mode   = MODE_IDLE;
            end
            CMD_DISABLE: begin
                m_en = 1'b0;
                clear_transfer();
            end
            default: ;
        endcase
        r.launched       = s_launch;
        r.transfer_bytes = s_bytes;
        r.gyro_select    = (m_mode == MODE_GYRO);
        r.accel_select   = (m_mode == MODE_ACCEL);
        r.bus_abort      = s_abort;
        r.published      = s_pub;
        r.sample_valid   = m_valid;
        r.sample_seq     = m_seq;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: predict each accepted beat, then offer the next one or idle
    // ------------------------------------------------------------------
    always @(posedge clk) begin : event_driver
        sched_event_t ev;
        if (rst_n) begin
            // Predict from the payload that was on the port at this edge.
            if (in_valid && !in_stall)
                read_plan_q.push_back(schedule_step({cmd, now, bus_ready, start_ok}));
            // Hold a stalled beat; otherwise advance or go idle.
            if (!in_valid || !in_stall) begin
                if (bus_event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    ev = bus_event_q.pop_front();
                    in_valid  <= 1'b1;
                    cmd       <= ev.code;
                    now       <= ev.stamp;
                    bus_ready <= ev.rdy;
                    start_ok  <= ev.ok;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result beat with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge clk) begin : result_monitor
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (read_plan_q.size() == 0) begin
                $display("%0t: result beat with nothing predicted, expected none, actual seq %0h",
                         $time, sample_seq);
                fault_count++;
            end
            else begin
                want = read_plan_q.pop_front();
                check_field("launched", 32'(want.launched), 32'(launched));
                check_field("transfer_bytes", 32'(want.transfer_bytes), 32'(transfer_bytes));
                check_field("gyro_select", 32'(want.gyro_select), 32'(gyro_select));
                check_field("accel_select", 32'(want.accel_select), 32'(accel_select));
                check_field("bus_abort", 32'(want.bus_abort), 32'(bus_abort));
                check_field("published", 32'(want.published), 32'(published));
                check_field("sample_valid", 32'(want.sample_valid), 32'(sample_valid));
                check_field("sample_seq", 32'(want.sample_seq), 32'(sample_seq));
            end
        end
        out_stall <= (hold_left > 1) || ($urandom_range(99) < recv_idle_pct);
    end

    // Long receiver hold-off so the pipeline fills and back-pressures the sender
    always @(posedge clk) begin
        if (hold_start)
            hold_left <= 80;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_event(logic [CMD_WIDTH-1:0] code,
                                       logic [IMU_TIME_WIDTH-1:0] stamp,
                                       logic rdy, logic ok);
        sched_event_t ev;
        ev.code  = code;
        ev.stamp = stamp;
        ev.rdy   = rdy;
        ev.ok    = ok;
        bus_event_q.push_back(ev);
    endfunction

    // Advance the millisecond clock: mostly small steps, sometimes far, rarely anywhere.
    function automatic logic [IMU_TIME_WIDTH-1:0] tick();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            t_stamp = t_stamp + $urandom_range(0, 2);
        else if (r < 94)
            t_stamp = t_stamp + $urandom_range(3, 12);
        else if (r < 99)
            t_stamp = t_stamp + $urandom_range(13, 400);
        else
            t_stamp = $urandom();
        return t_stamp;
    endfunction

    function automatic logic mostly_one(int unsigned pct);
        return ($urandom_range(99) < pct);
    endfunction

    // Fill one phase: well-formed read rounds with random content, plus noise beats.
    function automatic void fill_phase();
        int unsigned n;
        int unsigned sel;
        n = 0;
        while (n < PHASE_ITEMS) begin
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(99) < 4) begin
                    push_event(CMD_ENABLE, tick(), mostly_one(90), mostly_one(90));
                    n++;
                end
                sel = $urandom_range(3);
                if (sel[0]) begin
                    push_event(CMD_GYRO_READY, tick(), mostly_one(90), mostly_one(90));
                    n++;
                end
                if (sel[1]) begin
                    push_event(CMD_ACCEL_READY, tick(), mostly_one(90), mostly_one(90));
                    n++;
                end
                push_event(CMD_POLL, tick(), mostly_one(88), mostly_one(90));
                push_event(CMD_XFER_DONE, tick(), mostly_one(95), mostly_one(90));
                push_event(CMD_XFER_DONE, tick(), mostly_one(95), mostly_one(90));
                n += 3;
            end
            else begin
                sel = $urandom_range(99);
                if (sel < 3)
                    push_event(CMD_UNUSED, tick(), 1'($urandom_range(1)),
                               1'($urandom_range(1)));
                else if (sel < 8)
                    push_event(CMD_XFER_ERROR, tick(), 1'($urandom_range(1)),
                               1'($urandom_range(1)));
                else if (sel < 12)
                    push_event(CMD_DISABLE, tick(), 1'($urandom_range(1)),
                               1'($urandom_range(1)));
                else
                    push_event(CMD_WIDTH'($urandom_range(CMD_POLL, CMD_ENABLE)), tick(),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
                n++;
            end
        end
    endfunction

    // Wait until the block holds no event, then let it idle before returning.
    task automatic wait_drained();
        while (bus_event_q.size() != 0 || in_valid || read_plan_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_FALLBACK_MS)
            m_fallback = val;
        else if (idx == CFG_TIMEOUT_MS)
            m_timeout = val;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Hold reset, then release on a rising edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed beats at the reset register values.
        push_event(CMD_POLL, 32'd0, 1'b1, 1'b1);          // disabled: no effect
        push_event(CMD_GYRO_READY, 32'd0, 1'b1, 1'b1);    // disabled: no effect
        push_event(CMD_XFER_DONE, 32'd0, 1'b0, 1'b1);     // idle done, unready bus: abort
        push_event(CMD_XFER_ERROR, 32'd1, 1'b1, 1'b0);    // error while disabled
        push_event(CMD_ENABLE, 32'd100, 1'b1, 1'b1);
        push_event(CMD_POLL, 32'd100, 1'b1, 1'b1);        // both pending: gyro first
        push_event(CMD_ACCEL_READY, 32'd100, 1'b1, 1'b1);
        push_event(CMD_XFER_DONE, 32'd101, 1'b1, 1'b1);   // gyro in, accel follows
        push_event(CMD_XFER_DONE, 32'd102, 1'b1, 1'b1);   // sample complete
        push_event(CMD_GYRO_READY, 32'd103, 1'b1, 1'b1);
        push_event(CMD_ACCEL_READY, 32'd103, 1'b1, 1'b1);
        push_event(CMD_POLL, 32'd103, 1'b0, 1'b1);        // bus not ready: stay pending
        push_event(CMD_POLL, 32'd104, 1'b1, 1'b0);        // launch refused
        push_event(CMD_POLL, 32'd200, 1'b1, 1'b1);        // fallback re-request
        push_event(CMD_POLL, 32'd300, 1'b0, 1'b1);        // stuck transfer: forced reset
        push_event(CMD_ENABLE, 32'd301, 1'b1, 1'b1);      // enable while busy
        push_event(CMD_POLL, 32'd301, 1'b1, 1'b1);
        push_event(CMD_DISABLE, 32'd302, 1'b0, 1'b1);     // disable mid-transfer
        push_event(CMD_UNUSED, 32'd302, 1'b1, 1'b1);
        push_event(CMD_ENABLE, 32'hFFFF_FFFE, 1'b1, 1'b1);
        push_event(CMD_POLL, 32'd2, 1'b1, 1'b1);          // time wraps
        push_event(CMD_XFER_DONE, 32'd3, 1'b1, 1'b1);
        push_event(CMD_XFER_DONE, 32'd9, 1'b1, 1'b1);
        push_event(CMD_XFER_DONE, 32'd10, 1'b1, 1'b1);    // done while idle
        push_event(CMD_POLL, 32'd20, 1'b1, 1'b1);
        t_stamp = 32'd20;
        wait_drained();

        // Phase one: shortest fallback, longest timeout.
        write_reg(CFG_FALLBACK_MS, 8'd0);
        write_reg(CFG_TIMEOUT_MS, 8'd255);
        fill_phase();
        wait_drained();

        // Phase two: swap idle rates and register extremes.
        send_idle_pct <= 51;
        recv_idle_pct <= 24;
        write_reg(CFG_FALLBACK_MS, 8'd255);
        write_reg(CFG_TIMEOUT_MS, 8'd0);
        fill_phase();
        wait_drained();

        // Phase three: no idling, mid-range registers, one long receiver hold-off.
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_reg(CFG_FALLBACK_MS, CFG_WIDTH'($urandom_range(1, 20)));
        write_reg(CFG_TIMEOUT_MS, CFG_WIDTH'($urandom_range(1, 20)));
        fill_phase();
        repeat (3) @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        wait_drained();

        if (read_plan_q.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, read_plan_q.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("imu_dual_sensor_read_scheduler_top verification clean");
        else
            $display("imu_dual_sensor_read_scheduler_top verification failed");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("imu_dual_sensor_read_scheduler_top verification failed");
        $finish;
    end

endmodule
